>>> rtl/cfa_pkg.sv
// Shared widths, operation and status codes, and controller/datapath interface types.
package cfa_pkg;

   localparam int MANT_W    = 24;
   localparam int EXP_W     = 13;
   localparam int FRAC      = MANT_W - 1;
   localparam int ALIGN     = 66;
   localparam int SUM_W     = MANT_W + ALIGN + 1;
   localparam int EXT_W     = 16;
   localparam int DIV_STEPS = FRAC + 2;
   localparam int CNT_W     = $clog2(DIV_STEPS + 1);

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_DIV_ZERO = 2'd1;
   localparam logic [1:0] ST_RANGE    = 2'd2;
   localparam logic [1:0] ST_UNUSED   = 2'd3;

   typedef struct packed {
      logic load;
      logic prep;
      logic sum;
      logic norm;
      logic div_step;
      logic finish;
   } cfa_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       norm_done;
   } cfa_stat_type;

endpackage

>>> rtl/cfa_ctrl.sv
// Sequencing controller for the floating-point unit.
module cfa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  cfa_pkg::cfa_stat_type stat,
   output cfa_pkg::cfa_cmd_type  cmd,
   output logic                 busy,
   output logic                 rsp_valid
);
   import cfa_pkg::*;

   typedef enum logic [2:0] {IDLE, PREP, SUM, NORM, DIVIDE, FINISH} state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              valid_ff, valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      count_in = count_ff;
      valid_in = 1'b0;
      unique case (state_ff)
         IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = PREP;
            end
         end
         PREP: begin
            cmd.prep = 1'b1;
            count_in = '0;
            state_in = (stat.op == OP_DIV) ? DIVIDE : SUM;
         end
         SUM: begin
            cmd.sum  = 1'b1;
            state_in = NORM;
         end
         NORM: begin
            if (stat.norm_done) state_in = FINISH;
            else cmd.norm = 1'b1;
         end
         DIVIDE: begin
            cmd.div_step = 1'b1;
            count_in     = count_ff + 1'b1;
            if (count_ff == CNT_W'(DIV_STEPS - 1)) state_in = FINISH;
         end
         FINISH: begin
            cmd.finish = 1'b1;
            valid_in   = 1'b1;
            state_in   = IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = (state_ff != IDLE);
   assign rsp_valid = valid_ff;

endmodule

>>> rtl/cfa_datapath.sv
// Operand registers, alignment, add, multiply, divide and normalize datapath.
module cfa_datapath (
   input  logic                              clock,
   input  cfa_pkg::cfa_cmd_type              cmd,
   output cfa_pkg::cfa_stat_type             stat,
   input  logic [1:0]                        req_operation,
   input  logic                              req_a_sign,
   input  logic [cfa_pkg::MANT_W-1:0]        req_a_mantissa,
   input  logic signed [cfa_pkg::EXP_W-1:0]  req_a_exponent,
   input  logic                              req_b_sign,
   input  logic [cfa_pkg::MANT_W-1:0]        req_b_mantissa,
   input  logic signed [cfa_pkg::EXP_W-1:0]  req_b_exponent,
   output logic                              rsp_res_sign,
   output logic [cfa_pkg::MANT_W-1:0]        rsp_res_mantissa,
   output logic signed [cfa_pkg::EXP_W-1:0]  rsp_res_exponent,
   output logic [1:0]                        rsp_status
);
   import cfa_pkg::*;

   function automatic logic [4:0] lead24(input logic [MANT_W-1:0] v);
      logic [4:0] p;
      p = '0;
      for (int i = 0; i < MANT_W; i++) begin
         if (v[i]) p = 5'(i);
      end
      return p;
   endfunction

   logic [1:0]              op_ff;
   logic                    as_ff, bs_ff;
   logic [MANT_W-1:0]       ma_ff, mb_ff;
   logic signed [EXT_W-1:0] ea_ff, eb_ff;

   logic [SUM_W-1:0]        x_ff, y_ff, s_ff;
   logic                    sx_ff, sy_ff, sign_ff;
   logic signed [EXT_W-1:0] ex_ff;
   logic                    zero_ff, dz_ff;
   logic [2*MANT_W-1:0]     prod_ff;
   logic [6:0]              p_ff;
   logic [MANT_W:0]         rem_ff, q_ff;
   logic [MANT_W-1:0]       dv_ff;

   logic                    rsp_sign_ff;
   logic [MANT_W-1:0]       rsp_mant_ff;
   logic signed [EXP_W-1:0] rsp_exp_ff;
   logic [1:0]              rsp_status_ff;

   // alignment for add and subtract
   logic                    beff;
   logic                    swap;
   logic [MANT_W-1:0]       mx, my;
   logic signed [EXT_W-1:0] exs, eys;
   logic [EXT_W-1:0]        d;
   logic [EXT_W-1:0]        sh;
   logic [SUM_W-1:0]        y_in;
   logic [MANT_W-1:0]       keep;
   logic                    sticky;
   logic [4:0]              la, lb;

   always_comb begin
      beff = bs_ff ^ (op_ff == OP_SUB);
      swap = !((mb_ff == '0) || ((ma_ff != '0) && (ea_ff >= eb_ff)));
      mx   = swap ? mb_ff : ma_ff;
      my   = swap ? ma_ff : mb_ff;
      exs  = swap ? eb_ff : ea_ff;
      eys  = swap ? ea_ff : eb_ff;
      d    = EXT_W'(exs - eys);
      sh   = d - EXT_W'(ALIGN - 1);
      keep   = '0;
      sticky = 1'b1;
      y_in   = '0;
      if (my != '0) begin
         if (d <= EXT_W'(ALIGN)) begin
            y_in = SUM_W'(my) << (EXT_W'(ALIGN) - d);
         end else begin
            if (sh < EXT_W'(MANT_W)) begin
               keep   = my >> sh;
               sticky = (my & ~({MANT_W{1'b1}} << sh)) != '0;
            end
            y_in = SUM_W'({keep, 1'b0}) | SUM_W'(sticky);
         end
      end
      la = lead24(ma_ff);
      lb = lead24(mb_ff);
   end

   // wide add and subtract, or product load for multiply
   logic [SUM_W-1:0] s_in;
   logic             sign_in, sumz_in;

   always_comb begin
      s_in    = '0;
      sign_in = sx_ff;
      sumz_in = 1'b0;
      if (op_ff == OP_MUL) begin
         s_in    = {prod_ff[2*MANT_W-1:FRAC], {ALIGN{1'b0}}};
         sumz_in = (prod_ff[2*MANT_W-1:FRAC] == '0);
      end else if (sx_ff == sy_ff) begin
         s_in = x_ff + y_ff;
      end else if (x_ff > y_ff) begin
         s_in = x_ff - y_ff;
      end else if (x_ff < y_ff) begin
         s_in    = y_ff - x_ff;
         sign_in = sy_ff;
      end else begin
         sumz_in = 1'b1;
      end
   end

   // divide step
   logic [MANT_W:0] diff;
   logic            ge;

   assign ge   = rem_ff >= {1'b0, dv_ff};
   assign diff = rem_ff - {1'b0, dv_ff};

   // final result
   logic [63:0]             top;
   logic                    rnd;
   logic [64:0]             inc;
   logic [6:0]              pf;
   logic [MANT_W-1:0]       mant_f;
   logic signed [EXT_W-1:0] exp_f;
   logic                    sign_f;
   logic [1:0]              stat_f;
   logic                    chk;

   always_comb begin
      top    = s_ff[SUM_W-1:SUM_W-64];
      rnd    = s_ff[SUM_W-65] && ((|s_ff[SUM_W-66:0]) || s_ff[SUM_W-64]);
      inc    = {1'b0, top} + 65'(rnd);
      pf     = p_ff;
      mant_f = inc[63:64-MANT_W];
      if (inc[64]) begin
         mant_f = {1'b1, {(MANT_W-1){1'b0}}};
         pf     = p_ff + 7'd1;
      end
      exp_f  = ex_ff + $signed({9'b0, pf}) - EXT_W'(SUM_W - 2);
      sign_f = sign_ff;
      stat_f = ST_OK;
      chk    = 1'b1;
      if (op_ff == OP_DIV) begin
         if (zero_ff) begin
            sign_f = 1'b0;
            mant_f = '0;
            exp_f  = '0;
            chk    = 1'b0;
            stat_f = dz_ff ? ST_DIV_ZERO : ST_OK;
         end else if (q_ff[MANT_W]) begin
            mant_f = q_ff[MANT_W:1];
            exp_f  = ex_ff;
         end else begin
            mant_f = q_ff[MANT_W-1:0];
            exp_f  = ex_ff - EXT_W'(1);
         end
      end else if (zero_ff) begin
         mant_f = '0;
         if (op_ff == OP_MUL) begin
            exp_f = ex_ff;
         end else begin
            sign_f = 1'b0;
            exp_f  = '0;
            chk    = 1'b0;
         end
      end
      if (chk && (exp_f > EXT_W'((1 << (EXP_W-1)) - 1)
                  || exp_f < -$signed(EXT_W'(1 << (EXP_W-1))))) stat_f = ST_RANGE;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_operation;
         as_ff <= req_a_sign;
         bs_ff <= req_b_sign;
         ma_ff <= req_a_mantissa;
         mb_ff <= req_b_mantissa;
         ea_ff <= EXT_W'(req_a_exponent);
         eb_ff <= EXT_W'(req_b_exponent);
      end
      if (cmd.prep) begin
         unique case (op_ff)
            OP_ADD, OP_SUB: begin
               x_ff    <= {1'b0, mx, {ALIGN{1'b0}}};
               y_ff    <= y_in;
               sx_ff   <= swap ? beff : as_ff;
               sy_ff   <= swap ? as_ff : beff;
               ex_ff   <= exs;
               zero_ff <= (ma_ff == '0) && (mb_ff == '0);
            end
            OP_MUL: begin
               prod_ff <= ma_ff * mb_ff;
               sx_ff   <= as_ff ^ bs_ff;
               sy_ff   <= as_ff ^ bs_ff;
               ex_ff   <= ea_ff + eb_ff;
               zero_ff <= 1'b0;
            end
            OP_DIV: begin
               rem_ff  <= {1'b0, ma_ff << (5'(FRAC) - la)};
               dv_ff   <= mb_ff << (5'(FRAC) - lb);
               q_ff    <= '0;
               sign_ff <= as_ff ^ bs_ff;
               ex_ff   <= ea_ff - eb_ff + EXT_W'(la) - EXT_W'(lb);
               zero_ff <= (ma_ff == '0) || (mb_ff == '0);
               dz_ff   <= (mb_ff == '0);
            end
            default: ;
         endcase
      end
      if (cmd.sum) begin
         s_ff    <= sumz_in ? '0 : s_in;
         sign_ff <= sign_in;
         p_ff    <= 7'(SUM_W - 1);
         if (sumz_in) zero_ff <= 1'b1;
      end
      if (cmd.norm) begin
         if (s_ff[SUM_W-1 -: 16] == '0) begin
            s_ff <= s_ff << 16;
            p_ff <= p_ff - 7'd16;
         end else begin
            s_ff <= s_ff << 1;
            p_ff <= p_ff - 7'd1;
         end
      end
      if (cmd.div_step) begin
         q_ff   <= {q_ff[MANT_W-1:0], ge};
         rem_ff <= ge ? {diff[MANT_W-1:0], 1'b0} : {rem_ff[MANT_W-1:0], 1'b0};
      end
      if (cmd.finish) begin
         rsp_sign_ff   <= sign_f;
         rsp_mant_ff   <= mant_f;
         rsp_exp_ff    <= exp_f[EXP_W-1:0];
         rsp_status_ff <= stat_f;
      end
   end

   assign stat.op        = op_ff;
   assign stat.norm_done = s_ff[SUM_W-1] || (s_ff == '0);

   assign rsp_res_sign     = rsp_sign_ff;
   assign rsp_res_mantissa = rsp_mant_ff;
   assign rsp_res_exponent = rsp_exp_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

>>> rtl/custom_float_alu_top.sv
// Top level of the sign-magnitude floating-point add/sub/mul/div unit.
// An operation is taken when start is high and busy is low; busy stays high until the
// result beat, which appears for one cycle with rsp_valid and cannot be stalled. Add,
// subtract and multiply normalize the 91-bit sum 16 bits or 1 bit at a time; divide
// runs a 25-step restoring quotient loop. A new start is accepted in the same cycle the
// previous result beat is shown.
module custom_float_alu_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_operation,
   input  logic                              req_a_sign,
   input  logic [cfa_pkg::MANT_W-1:0]        req_a_mantissa,
   input  logic signed [cfa_pkg::EXP_W-1:0]  req_a_exponent,
   input  logic                              req_b_sign,
   input  logic [cfa_pkg::MANT_W-1:0]        req_b_mantissa,
   input  logic signed [cfa_pkg::EXP_W-1:0]  req_b_exponent,
   output logic                              rsp_valid,
   output logic                              rsp_res_sign,
   output logic [cfa_pkg::MANT_W-1:0]        rsp_res_mantissa,
   output logic signed [cfa_pkg::EXP_W-1:0]  rsp_res_exponent,
   output logic [1:0]                        rsp_status
);
   import cfa_pkg::*;

   cfa_cmd_type  cmd;
   cfa_stat_type stat;

   cfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   cfa_datapath u_datapath (
      .clock            (clock),
      .cmd              (cmd),
      .stat             (stat),
      .req_operation    (req_operation),
      .req_a_sign       (req_a_sign),
      .req_a_mantissa   (req_a_mantissa),
      .req_a_exponent   (req_a_exponent),
      .req_b_sign       (req_b_sign),
      .req_b_mantissa   (req_b_mantissa),
      .req_b_exponent   (req_b_exponent),
      .rsp_res_sign     (rsp_res_sign),
      .rsp_res_mantissa (rsp_res_mantissa),
      .rsp_res_exponent (rsp_res_exponent),
      .rsp_status       (rsp_status)
   );

   a_valid_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result beat while busy");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted beat did not raise busy");

   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result beat repeated");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != ST_UNUSED)) else $error("bad status code");

endmodule

>>> tb/sv/custom_float_alu_checker.sv
// Checker: predicts each float ALU result from the accepted operands and compares beats.
`timescale 1ns / 100ps
module custom_float_alu_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic [1:0]                        req_operation,
   input  logic                              req_a_sign,
   input  logic [cfa_pkg::MANT_W-1:0]        req_a_mantissa,
   input  logic signed [cfa_pkg::EXP_W-1:0]  req_a_exponent,
   input  logic                              req_b_sign,
   input  logic [cfa_pkg::MANT_W-1:0]        req_b_mantissa,
   input  logic signed [cfa_pkg::EXP_W-1:0]  req_b_exponent,
   input  logic                              rsp_valid,
   input  logic                              rsp_res_sign,
   input  logic [cfa_pkg::MANT_W-1:0]        rsp_res_mantissa,
   input  logic signed [cfa_pkg::EXP_W-1:0]  rsp_res_exponent,
   input  logic [1:0]                        rsp_status,
   output int                                errors,
   output int                                pending
);
   import cfa_pkg::*;

   typedef struct {
      logic              sign;
      logic [MANT_W-1:0] mant;
      int                exp;
      logic [1:0]        status;
   } exact_result_type;

   typedef struct packed {
      logic              sign;
      logic [MANT_W-1:0] mant;
      logic [EXP_W-1:0]  exp;
      logic [1:0]        status;
   } alu_result_type;

   alu_result_type expected_results[$];

   function automatic int msb_index(logic [127:0] v);
      int p;
      p = -1;
      for (int i = 0; i < 128; i++)
         if (v[i]) p = i;
      return p;
   endfunction

   function automatic exact_result_type zero_result(logic [1:0] st);
      exact_result_type r;
      r.sign = 1'b0; r.mant = '0; r.exp = 0; r.status = st;
      return r;
   endfunction

   function automatic exact_result_type sum_of(logic as, logic [63:0] ma, int ea,
                                               logic bs, logic [63:0] mb, int eb);
      exact_result_type r;
      logic sx, sy, guard, rest;
      logic [63:0] mx, my, keep, top;
      logic [127:0] x, y, s;
      int ex, ey, d, sh, p, l;
      if (ma == 0 && mb == 0) return zero_result(ST_OK);
      if (mb == 0 || (ma != 0 && ea >= eb)) begin
         sx = as; mx = ma; ex = ea; sy = bs; my = mb; ey = eb;
      end else begin
         sx = bs; mx = mb; ex = eb; sy = as; my = ma; ey = ea;
      end
      x = {64'd0, mx} << ALIGN;
      y = '0;
      if (my != 0) begin
         d = ex - ey;
         if (d <= ALIGN) begin
            y = {64'd0, my} << (ALIGN - d);
         end else begin
            sh = d - (ALIGN - 1);
            if (sh >= 64) y = 128'd1;
            else begin
               keep = my >> sh;
               y = {64'd0, keep} << 1;
               y[0] = |(my & ((64'd1 << sh) - 64'd1));
            end
         end
      end
      r.status = ST_OK;
      if (sx == sy) begin
         s = x + y; r.sign = sx;
      end else if (x == y) begin
         return zero_result(ST_OK);
      end else if (x > y) begin
         s = x - y; r.sign = sx;
      end else begin
         s = y - x; r.sign = sy;
      end
      p = msb_index(s);
      if (p <= 63) begin
         top = s[63:0] << (63 - p);
      end else begin
         l = p - 63;
         guard = s[l-1];
         rest = (l > 1) ? |(s & ((128'd1 << (l - 1)) - 128'd1)) : 1'b0;
         top = 64'(s >> l);
         if (guard && (rest || top[0])) begin
            top = top + 64'd1;
            if (top == 0) begin
               top = 64'd1 << 63; p++;
            end
         end
      end
      r.mant = MANT_W'(top >> (63 - FRAC));
      r.exp = ex + p - FRAC - ALIGN;
      return r;
   endfunction

   function automatic exact_result_type product_of(logic as, logic [63:0] ma, int ea,
                                                   logic bs, logic [63:0] mb, int eb);
      exact_result_type r;
      logic [63:0] m;
      int e, l;
      m = (ma * mb) >> FRAC;
      e = ea + eb;
      if (m != 0) begin
         l = msb_index({64'd0, m});
         if (l > FRAC) begin
            m = m >> (l - FRAC); e += l - FRAC;
         end else if (l < FRAC) begin
            m = m << (FRAC - l); e -= FRAC - l;
         end
      end
      r.sign = as ^ bs; r.mant = MANT_W'(m); r.exp = e; r.status = ST_OK;
      return r;
   endfunction

   function automatic exact_result_type quotient_of(logic as, logic [63:0] ma, int ea,
                                                    logic bs, logic [63:0] mb, int eb);
      exact_result_type r;
      logic [63:0] a, b, q;
      int la, lb, e;
      if (mb == 0) return zero_result(ST_DIV_ZERO);
      if (ma == 0) return zero_result(ST_OK);
      la = msb_index({64'd0, ma});
      lb = msb_index({64'd0, mb});
      a = ma << (62 - la);
      b = mb << (62 - lb);
      q = '0;
      for (int i = 0; i < DIV_STEPS; i++) begin
         q = q << 1;
         if (a >= b) begin
            q[0] = 1'b1; a = a - b;
         end
         a = a << 1;
      end
      e = ea - eb + la - lb;
      if (q >= (64'd1 << (FRAC + 1))) q = q >> 1;
      else e -= 1;
      r.sign = as ^ bs; r.mant = MANT_W'(q); r.exp = e; r.status = ST_OK;
      return r;
   endfunction

   function automatic alu_result_type predict_alu(logic [1:0] op, logic as,
         logic [MANT_W-1:0] ma, logic signed [EXP_W-1:0] ea, logic bs,
         logic [MANT_W-1:0] mb, logic signed [EXP_W-1:0] eb);
      exact_result_type r;
      alu_result_type o;
      case (op)
         OP_ADD: r = sum_of(as, 64'(ma), int'(ea), bs, 64'(mb), int'(eb));
         OP_SUB: r = sum_of(as, 64'(ma), int'(ea), ~bs, 64'(mb), int'(eb));
         OP_MUL: r = product_of(as, 64'(ma), int'(ea), bs, 64'(mb), int'(eb));
         default: r = quotient_of(as, 64'(ma), int'(ea), bs, 64'(mb), int'(eb));
      endcase
      if (r.status == ST_OK && (r.exp > (2 ** (EXP_W - 1)) - 1 || r.exp < -(2 ** (EXP_W - 1))))
         r.status = ST_RANGE;
      o.sign = r.sign; o.mant = r.mant; o.exp = EXP_W'(r.exp); o.status = r.status;
      return o;
   endfunction

   always @(posedge clock) begin
      alu_result_type want;
      if (reset) begin
         expected_results.delete();
         errors = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected result beat sign=%0b mant=%h exp=%0d status=%0d",
                        $time, rsp_res_sign, rsp_res_mantissa, rsp_res_exponent, rsp_status);
            end else begin
               want = expected_results.pop_front();
               if (rsp_res_sign !== want.sign) begin
                  errors++;
                  $display("%0t: sign expected %0b actual %0b", $time, want.sign, rsp_res_sign);
               end
               if (rsp_res_mantissa !== want.mant) begin
                  errors++;
                  $display("%0t: mantissa expected %h actual %h", $time, want.mant,
                           rsp_res_mantissa);
               end
               if (rsp_res_exponent !== want.exp) begin
                  errors++;
                  $display("%0t: exponent expected %0d actual %0d", $time,
                           $signed(want.exp), rsp_res_exponent);
               end
               if (rsp_status !== want.status) begin
                  errors++;
                  $display("%0t: status expected %0d actual %0d", $time, want.status,
                           rsp_status);
               end
            end
         end
         if (start && !busy)
            expected_results.push_back(predict_alu(req_operation, req_a_sign,
               req_a_mantissa, req_a_exponent, req_b_sign, req_b_mantissa, req_b_exponent));
      end
      pending = expected_results.size();
   end

endmodule

>>> tb/sv/testbench.sv
// Top of the float ALU testbench: clock, reset, operand stimulus and the verdict.
`timescale 1ns / 100ps
module testbench;
   import cfa_pkg::*;

   logic                     clock = 0;
   logic                     reset = 1;
   logic                     start = 0;
   logic                     busy;
   logic [1:0]               req_operation = OP_ADD;
   logic                     req_a_sign = 0;
   logic [MANT_W-1:0]        req_a_mantissa = '0;
   logic signed [EXP_W-1:0]  req_a_exponent = '0;
   logic                     req_b_sign = 0;
   logic [MANT_W-1:0]        req_b_mantissa = '0;
   logic signed [EXP_W-1:0]  req_b_exponent = '0;
   logic                     rsp_valid;
   logic                     rsp_res_sign;
   logic [MANT_W-1:0]        rsp_res_mantissa;
   logic signed [EXP_W-1:0]  rsp_res_exponent;
   logic [1:0]               rsp_status;
   int                       errors;
   int                       pending;

   always #5 clock = ~clock;

   custom_float_alu_top dut (.*);
   custom_float_alu_checker checker_inst (.*);

   task automatic issue_op(logic [1:0] op, logic as, logic [MANT_W-1:0] ma, int ea,
                           logic bs, logic [MANT_W-1:0] mb, int eb);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_operation <= op;
      req_a_sign <= as; req_a_mantissa <= ma; req_a_exponent <= EXP_W'(ea);
      req_b_sign <= bs; req_b_mantissa <= mb; req_b_exponent <= EXP_W'(eb);
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   function automatic logic [MANT_W-1:0] random_mantissa();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return MANT_W'($urandom);
         2: return MANT_W'($urandom_range(1, 255));
         3: return {MANT_W{1'b1}};
         default: return MANT_W'($urandom) | (MANT_W'(1) << FRAC);
      endcase
   endfunction

   function automatic int random_exponent();
      case ($urandom_range(0, 7))
         0: return $urandom_range(0, 8191) - 4096;
         1: return $urandom_range(0, 1) ? 4095 - $urandom_range(0, 40)
                                        : -4096 + $urandom_range(0, 40);
         default: return $urandom_range(0, 160) - 80;
      endcase
   endfunction

   initial begin
      logic [MANT_W-1:0] m;
      int e;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (int op = 0; op < 4; op++) begin
         issue_op(2'(op), 1'b0, 24'h800000, 0, 1'b0, 24'h800000, 0);
         issue_op(2'(op), 1'b1, 24'hFFFFFF, 4095, 1'b0, 24'hFFFFFF, 4095);
         issue_op(2'(op), 1'b0, 24'h000001, -4096, 1'b1, 24'hFFFFFF, 4095);
         issue_op(2'(op), 1'b1, 24'h000000, 12, 1'b1, 24'h000000, -7);
         issue_op(2'(op), 1'b0, 24'h123456, 3, 1'b1, 24'h000000, 5);
      end
      issue_op(OP_SUB, 1'b0, 24'hABCDEF, 9, 1'b0, 24'hABCDEF, 9);
      issue_op(OP_ADD, 1'b1, 24'h800000, 4000, 1'b0, 24'h800001, -4000);
      issue_op(OP_ADD, 1'b0, 24'hFFFFFF, 0, 1'b0, 24'h000003, -70);
      issue_op(OP_DIV, 1'b0, 24'h000000, 3, 1'b1, 24'h400000, 2);
      issue_op(OP_MUL, 1'b1, 24'h000001, 2, 1'b0, 24'h000001, 3);
      start <= 0;
      do @(posedge clock); while (pending != 0);
      for (int i = 0; i < 480; i++) begin
         m = random_mantissa();
         e = random_exponent();
         if (i == 240) begin
            start <= 0;
            do @(posedge clock); while (pending != 0);
         end
         if ($urandom_range(0, 5) == 0)
            issue_op(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), m, e,
                     1'($urandom_range(0, 1)), m, $urandom_range(0, 1) ? e : e + 1);
         else
            issue_op(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), m, e,
                     1'($urandom_range(0, 1)), random_mantissa(), random_exponent());
      end
      start <= 0;
      do @(posedge clock); while (pending != 0);
      repeat (40) @(posedge clock);
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #2ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
